// ===== design/qrm_pkg.sv =====
// Shared types, constants and helpers of the qubit register measurement core.
`timescale 1ns / 1ps
package qrm_pkg;

    localparam int MAX_QUBITS = 10;
    localparam int DEPTH      = 1 << MAX_QUBITS;
    localparam int ADDR_W     = MAX_QUBITS;
    localparam int LEN_W      = ADDR_W + 1;
    localparam int AMP_W      = 32;
    localparam int FRAC_BITS  = 30;
    localparam int DVD_W      = AMP_W + FRAC_BITS;
    localparam int PROB_W     = 64;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_MEASALL = 2'd2;
    localparam logic [1:0] CMD_MEASONE = 2'd3;

    localparam logic REG_QUBIT_COUNT = 1'b0;
    localparam logic REG_COMPLEX     = 1'b1;

    localparam logic [AMP_W-1:0] AMP_ONE = 32'h4000_0000;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic [AMP_W-1:0] amp_mag(input logic [AMP_W-1:0] a);
        amp_mag = a[AMP_W-1] ? (~a + 32'd1) : a;
    endfunction

    // Restores the sign of a scaled magnitude and saturates to the Q1.30 word.
    function automatic logic [AMP_W-1:0] sat_scale(input logic neg,
                                                   input logic [DVD_W-1:0] q);
        logic [AMP_W-1:0] m;
        if (neg) begin
            m = (q > 62'h8000_0000) ? 32'h8000_0000 : q[AMP_W-1:0];
            sat_scale = 32'd0 - m;
        end else begin
            sat_scale = (q > 62'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[AMP_W-1:0];
        end
    endfunction

endpackage

// ===== design/qrm_div.sv =====
// Restoring divider, one quotient bit per cycle, for amplitude rescaling.
`timescale 1ns / 1ps
module qrm_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [qrm_pkg::DVD_W-1:0]  dividend,
    input  logic [qrm_pkg::AMP_W-1:0]  divisor,
    output qrm_pkg::unit_stat_t        stat,
    output logic [qrm_pkg::DVD_W-1:0]  quotient
);
    import qrm_pkg::*;

    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [AMP_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [AMP_W-1:0] dvs_reg, dvs_next;
    logic [AMP_W:0]   trial;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = 6'(DVD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so it fits one word.
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = AMP_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[AMP_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== design/qrm_sqrt.sv =====
// Integer square root of a 64-bit probability, two radicand bits per cycle.
`timescale 1ns / 1ps
module qrm_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [qrm_pkg::PROB_W-1:0]  radicand,
    output qrm_pkg::unit_stat_t         stat,
    output logic [qrm_pkg::AMP_W-1:0]   root
);
    import qrm_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [PROB_W-1:0] x_reg, x_next;
    logic [PROB_W-1:0] res_reg, res_next;
    logic [PROB_W-1:0] bit_reg, bit_next;
    logic [PROB_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            x_next    = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(PROB_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (x_reg >= trial) begin
                x_next   = x_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = res_reg[AMP_W-1:0];

endmodule

// ===== design/qubit_register_measurement_core.sv =====
// State vector of up to 1024 Q1.30 complex amplitudes with write, read, measure-all and
// measure-one commands; one command is worked at a time and s_ready is high only while
// the core is idle. With n qubits in use and L = 2^n, a write and a read each end with the
// output beat. Measure-all reads each entry and squares its parts through one shared 32x32
// multiplier, summing until the sum reaches the threshold; if it does, it then writes all L
// entries at one per cycle over the single write port, one to the chosen entry, zero to the rest.
// Measure-one sums the probabilities of all L entries, takes a square root, then rescales
// each kept entry in the bit-serial divider and clears each entry that is not kept.
`timescale 1ns / 1ps
module qubit_register_measurement_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_addr,
    input  logic [3:0]                    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [qrm_pkg::ADDR_W-1:0]    s_address,
    input  logic signed [31:0]            s_amp_real_in,
    input  logic signed [31:0]            s_amp_imag_in,
    input  logic [31:0]                   s_random_fraction,
    input  logic [3:0]                    s_qubit_select,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qrm_pkg::ADDR_W-1:0]    m_measured_index,
    output logic                          m_outcome,
    output logic                          m_found,
    output logic signed [31:0]            m_amp_real_out,
    output logic signed [31:0]            m_amp_imag_out
);
    import qrm_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RDW    = 4'd1;
    localparam logic [3:0] ST_P1_RD  = 4'd2;
    localparam logic [3:0] ST_P1_MR  = 4'd3;
    localparam logic [3:0] ST_P1_MI  = 4'd4;
    localparam logic [3:0] ST_P1_ACC = 4'd5;
    localparam logic [3:0] ST_CLR    = 4'd6;
    localparam logic [3:0] ST_SQ_GO  = 4'd7;
    localparam logic [3:0] ST_SQ_W   = 4'd8;
    localparam logic [3:0] ST_M2_CHK = 4'd9;
    localparam logic [3:0] ST_M2_RD  = 4'd10;
    localparam logic [3:0] ST_M2_DRE = 4'd11;
    localparam logic [3:0] ST_M2_DIM = 4'd12;
    localparam logic [3:0] ST_FIN    = 4'd13;

    // Amplitude stores.
    logic [AMP_W-1:0] mem_re [DEPTH];
    logic [AMP_W-1:0] mem_im [DEPTH];

    logic [3:0]       qcount_reg;
    logic             cplx_reg;
    logic [3:0]       eff_cnt;
    logic [LEN_W-1:0] len;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] chosen_reg, chosen_next;
    logic [3:0]        b_reg, b_next;
    logic [PROB_W-1:0] thr_reg, thr_next;
    logic [PROB_W-1:0] sum_reg, sum_next;
    logic [PROB_W-1:0] p1_reg, p1_next;
    logic [PROB_W-1:0] pr_reg, pr_next;
    logic [PROB_W-1:0] pi_reg, pi_next;
    logic              keep_reg, keep_next;
    logic [AMP_W-1:0]  s_reg, s_next;
    logic              re_neg_reg, re_neg_next;
    logic [AMP_W-1:0]  a_im_reg, a_im_next;
    logic [AMP_W-1:0]  q_re_reg, q_re_next;

    logic [ADDR_W-1:0] r_index_reg, r_index_next;
    logic              r_outcome_reg, r_outcome_next;
    logic              r_found_reg, r_found_next;
    logic [AMP_W-1:0]  r_re_reg, r_re_next;
    logic [AMP_W-1:0]  r_im_reg, r_im_next;

    logic              m_valid_reg;
    logic [ADDR_W-1:0] m_index_reg;
    logic              m_outcome_reg, m_found_reg;
    logic [AMP_W-1:0]  m_re_reg, m_im_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [AMP_W-1:0]  rd_re_reg, rd_im_reg;
    logic              we_re, we_im;
    logic [ADDR_W-1:0] wr_addr;
    logic [AMP_W-1:0]  wr_re, wr_im;

    logic [AMP_W-1:0]  mul_a;
    logic [PROB_W-1:0] mul_p;
    logic [PROB_W:0]   prob_w, acc_w;
    logic [PROB_W-1:0] prob, acc_sat;
    logic [ADDR_W-1:0] idx_sh;
    logic              half;
    logic              last;
    logic              accept;

    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    unit_stat_t        div_stat;
    logic [DVD_W-1:0]  div_q;
    logic              sq_start;
    logic [PROB_W-1:0] sq_in;
    unit_stat_t        sq_stat;
    logic [AMP_W-1:0]  sq_root;

    qrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (s_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    qrm_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_in),
        .stat     (sq_stat),
        .root     (sq_root)
    );

    always_comb begin
        eff_cnt = qcount_reg;
        if (qcount_reg == 4'd0) begin
            eff_cnt = 4'd1;
        end else if (qcount_reg > 4'(MAX_QUBITS)) begin
            eff_cnt = 4'(MAX_QUBITS);
        end
    end
    assign len = LEN_W'(1) << eff_cnt;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign last    = (idx_reg == len - LEN_W'(1));
    assign idx_sh  = idx_reg[ADDR_W-1:0] >> b_reg;
    assign half    = idx_sh[0];

    // The single multiplier squares the real part, then the imaginary part.
    assign mul_a  = amp_mag((state_reg == ST_P1_MR) ? rd_re_reg : rd_im_reg);
    assign mul_p  = PROB_W'(mul_a) * PROB_W'(mul_a);
    assign prob_w = {1'b0, pr_reg} + {1'b0, pi_reg};
    assign prob   = prob_w[PROB_W-1:0];
    always_comb begin
        if (cmd_reg == CMD_MEASONE && half) begin
            acc_w = {1'b0, p1_reg} + {1'b0, prob};
        end else begin
            acc_w = {1'b0, sum_reg} + {1'b0, prob};
        end
        acc_sat = acc_w[PROB_W] ? {PROB_W{1'b1}} : acc_w[PROB_W-1:0];
    end

    assign sq_in   = keep_reg ? p1_reg : sum_reg;
    assign div_dvd = (state_reg == ST_M2_RD) ? {amp_mag(rd_re_reg), {FRAC_BITS{1'b0}}}
                                             : {amp_mag(a_im_reg), {FRAC_BITS{1'b0}}};

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        chosen_next    = chosen_reg;
        b_next         = b_reg;
        thr_next       = thr_reg;
        sum_next       = sum_reg;
        p1_next        = p1_reg;
        pr_next        = pr_reg;
        pi_next        = pi_reg;
        keep_next      = keep_reg;
        s_next         = s_reg;
        re_neg_next    = re_neg_reg;
        a_im_next      = a_im_reg;
        q_re_next      = q_re_reg;
        r_index_next   = r_index_reg;
        r_outcome_next = r_outcome_reg;
        r_found_next   = r_found_reg;
        r_re_next      = r_re_reg;
        r_im_next      = r_im_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[ADDR_W-1:0];
        we_re          = 1'b0;
        we_im          = 1'b0;
        wr_addr        = idx_reg[ADDR_W-1:0];
        wr_re          = '0;
        wr_im          = '0;
        div_start      = 1'b0;
        sq_start       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next       = s_command;
                    idx_next       = '0;
                    sum_next       = '0;
                    p1_next        = '0;
                    thr_next       = {3'b000, s_random_fraction, 29'd0};
                    b_next         = eff_cnt - 4'd1 - s_qubit_select;
                    r_index_next   = '0;
                    r_outcome_next = 1'b0;
                    r_found_next   = 1'b0;
                    r_re_next      = '0;
                    r_im_next      = '0;
                    case (s_command)
                        CMD_WRITE: begin
                            if ({1'b0, s_address} < len) begin
                                we_re   = 1'b1;
                                we_im   = 1'b1;
                                wr_addr = s_address;
                                wr_re   = s_amp_real_in;
                                wr_im   = s_amp_imag_in;
                            end
                            state_next = ST_FIN;
                        end
                        CMD_READ: begin
                            if ({1'b0, s_address} < len) begin
                                rd_en      = 1'b1;
                                rd_addr    = s_address;
                                state_next = ST_RDW;
                            end else begin
                                state_next = ST_FIN;
                            end
                        end
                        CMD_MEASALL: state_next = ST_P1_RD;
                        default: begin
                            state_next = (s_qubit_select < eff_cnt) ? ST_P1_RD : ST_FIN;
                        end
                    endcase
                end
            end
            ST_RDW: begin
                r_re_next  = rd_re_reg;
                r_im_next  = cplx_reg ? rd_im_reg : '0;
                state_next = ST_FIN;
            end
            ST_P1_RD: begin
                rd_en      = 1'b1;
                state_next = ST_P1_MR;
            end
            ST_P1_MR: begin
                pr_next    = mul_p;
                state_next = ST_P1_MI;
            end
            ST_P1_MI: begin
                pi_next    = cplx_reg ? mul_p : '0;
                state_next = ST_P1_ACC;
            end
            ST_P1_ACC: begin
                idx_next   = idx_reg + LEN_W'(1);
                state_next = ST_P1_RD;
                if (cmd_reg == CMD_MEASALL) begin
                    sum_next = acc_sat;
                    if (acc_sat >= thr_reg) begin
                        chosen_next  = idx_reg[ADDR_W-1:0];
                        r_index_next = idx_reg[ADDR_W-1:0];
                        r_found_next = 1'b1;
                        idx_next     = '0;
                        state_next   = ST_CLR;
                    end else if (last) begin
                        state_next = ST_FIN;
                    end
                end else begin
                    // sum_reg holds the probability of zero, p1_reg that of one.
                    if (half) begin
                        p1_next = acc_sat;
                    end else begin
                        sum_next = acc_sat;
                    end
                    if (last) begin
                        state_next = ST_SQ_GO;
                    end
                end
            end
            ST_CLR: begin
                we_re    = 1'b1;
                we_im    = cplx_reg;
                wr_re    = (idx_reg[ADDR_W-1:0] == chosen_reg) ? AMP_ONE : '0;
                idx_next = idx_reg + LEN_W'(1);
                if (last) begin
                    state_next = ST_FIN;
                end
            end
            ST_SQ_GO: begin
                keep_next      = !(sum_reg > thr_reg);
                r_outcome_next = !(sum_reg > thr_reg);
                idx_next       = '0;
                state_next     = ST_SQ_W;
            end
            ST_SQ_W: begin
                if (sq_in == '0) begin
                    s_next     = '0;
                    state_next = ST_M2_CHK;
                end else if (sq_stat.done) begin
                    s_next     = sq_root;
                    state_next = ST_M2_CHK;
                end else if (!sq_stat.busy) begin
                    sq_start = 1'b1;
                end
            end
            ST_M2_CHK: begin
                if (half == keep_reg) begin
                    if (s_reg != '0) begin
                        rd_en      = 1'b1;
                        state_next = ST_M2_RD;
                    end else begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = last ? ST_FIN : ST_M2_CHK;
                    end
                end else begin
                    we_re      = 1'b1;
                    we_im      = cplx_reg;
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = last ? ST_FIN : ST_M2_CHK;
                end
            end
            ST_M2_RD: begin
                re_neg_next = rd_re_reg[AMP_W-1];
                a_im_next   = rd_im_reg;
                div_start   = 1'b1;
                state_next  = ST_M2_DRE;
            end
            ST_M2_DRE: begin
                if (div_stat.done) begin
                    q_re_next = sat_scale(re_neg_reg, div_q);
                    if (cplx_reg) begin
                        div_start  = 1'b1;
                        state_next = ST_M2_DIM;
                    end else begin
                        we_re      = 1'b1;
                        wr_re      = sat_scale(re_neg_reg, div_q);
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = last ? ST_FIN : ST_M2_CHK;
                    end
                end
            end
            ST_M2_DIM: begin
                if (div_stat.done) begin
                    we_re      = 1'b1;
                    we_im      = 1'b1;
                    wr_re      = q_re_reg;
                    wr_im      = sat_scale(a_im_reg[AMP_W-1], div_q);
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = last ? ST_FIN : ST_M2_CHK;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we_re) begin
            mem_re[wr_addr] <= wr_re;
        end
        if (we_im) begin
            mem_im[wr_addr] <= wr_im;
        end
        if (rd_en) begin
            rd_re_reg <= mem_re[rd_addr];
            rd_im_reg <= mem_im[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            qcount_reg  <= 4'd1;
            cplx_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_addr == REG_QUBIT_COUNT) begin
                    qcount_reg <= cfg_wdata;
                end else begin
                    cplx_reg <= cfg_wdata[0];
                end
            end
            if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
            m_index_reg   <= r_index_reg;
            m_outcome_reg <= r_outcome_reg;
            m_found_reg   <= r_found_reg;
            m_re_reg      <= r_re_reg;
            m_im_reg      <= r_im_reg;
        end
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        chosen_reg    <= chosen_next;
        b_reg         <= b_next;
        thr_reg       <= thr_next;
        sum_reg       <= sum_next;
        p1_reg        <= p1_next;
        pr_reg        <= pr_next;
        pi_reg        <= pi_next;
        keep_reg      <= keep_next;
        s_reg         <= s_next;
        re_neg_reg    <= re_neg_next;
        a_im_reg      <= a_im_next;
        q_re_reg      <= q_re_next;
        r_index_reg   <= r_index_next;
        r_outcome_reg <= r_outcome_next;
        r_found_reg   <= r_found_next;
        r_re_reg      <= r_re_next;
        r_im_reg      <= r_im_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_measured_index = m_index_reg;
    assign m_outcome        = m_outcome_reg;
    assign m_found          = m_found_reg;
    assign m_amp_real_out   = m_re_reg;
    assign m_amp_imag_out   = m_im_reg;

    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> ({1'b0, m_measured_index} < len))
        else $error("measured index beyond the vector");

    a_found_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_outcome && m_amp_real_out == 0 && m_amp_imag_out == 0)
        else $error("measure-all beat carries other result fields");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_no_write_during_sqrt: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_stat.busy |-> !we_re && !we_im)
        else $error("store written while the square root runs");

    a_busy_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sq_stat.busy && div_stat.busy))
        else $error("divider and square root busy together");

endmodule
